/* src/mpfd_pkg.sv */
// Shared types, widths and constants for the median-filtered PID fan duty block.
`default_nettype none
package mpfd_pkg;

    // Sample and window widths
    localparam int ADC_BITS = 12;
    localparam int SAMPLE_W = 12;
    localparam int WIN_W    = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;

    // Temperature in Q12 degrees
    localparam int TEMP_W = 21;
    localparam logic [TEMP_W-1:0] T_MAX = {TEMP_W{1'b1}};
    localparam int TEMP_SCALE = 500 * 4096;
    localparam int FRAC_BITS  = 12;

    // Datapath widths
    localparam int ERR_W   = 26;
    localparam int DT_W    = TEMP_W + 1;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 26;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int INTEG_W = 48;
    localparam int ISUM_W  = INTEG_W + 1;
    localparam int IHALF_W = 24;
    localparam int KPROD_W = 41;
    localparam int FULL_W  = 66;
    localparam int SUM_W   = 62;

    localparam int ISTEP_SHIFT = 20;
    localparam int PROP_SHIFT  = 4;
    localparam int KP_SHIFT    = 8;
    localparam int DUTY_SHIFT  = 25;

    localparam logic signed [INTEG_W-1:0] I_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] I_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Duty
    localparam int DUTY_W = 9;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 9'd111;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_DERIV_GAIN   = 3'd1,
        REG_INTEG_STEP   = 3'd2,
        REG_DESIRED_TEMP = 3'd3,
        REG_OUTPUT_MAX   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [15:0]       prop_gain;
        logic [23:0]       derivative_gain;
        logic [31:0]       integral_step;
        logic [7:0]        desired_temp;
        logic [DUTY_W-1:0] output_max;
    } cfg_t;

    localparam logic [15:0]       PROP_GAIN_RESET    = 16'd256;
    localparam logic [23:0]       DERIV_GAIN_RESET   = 24'd200000;
    localparam logic [31:0]       INTEG_STEP_RESET   = 32'd64425;
    localparam logic [7:0]        DESIRED_TEMP_RESET = 8'd20;
    localparam logic [DUTY_W-1:0] OUTPUT_MAX_RESET   = 9'd250;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_T,
        ST_TEMP,
        ST_MUL_D,
        ST_MUL_I,
        ST_MUL_P,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_INTEG,
        ST_SCALE,
        ST_TOTAL
    } state_t;

endpackage
`default_nettype wire

/* src/median_pid_fan_duty_core.sv */
// Top level: median-filtered PID fan duty controller around one shared multiplier.
// A pair that does not complete a window group is taken without leaving the idle state.
// The third pair of a group starts a ten-step sequence on the shared multiplier:
// the result is registered as the final step retires, and s_tready is low meanwhile.
// No new pair is taken until the sequence is back at rest; a result still waiting
// on m_tready holds the final step and stretches it.
// Reset is synchronous, active low: windows, PID state and registers return to
// their reset values and the duty restarts at 111.
`default_nettype none
module median_pid_fan_duty_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Input channel
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [23:0]                  s_tdata,   // [11:0] temp_sample, [23:12] pot_sample
    // Result channel
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [31:0]                  m_tdata,   // [8:0] duty_compare, [29:9] temperature_q12
    // Configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mpfd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mpfd_pkg::DATA_W-1:0]  pwdata,
    output logic      [mpfd_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);
    import mpfd_pkg::*;

    cfg_t cfg;

    // Window and median
    logic             in_xfer;
    logic             group_done;
    logic [WIN_W-1:0] temp_med;
    logic [WIN_W-1:0] pot_med;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    // Sequencer and PID state
    state_t                    state_reg,     state_next;
    logic        [TEMP_W-1:0]  cur_temp_reg,  cur_temp_next;
    logic        [TEMP_W-1:0]  prev_temp_reg, prev_temp_next;
    logic signed [INTEG_W-1:0] integ_acc_reg, integ_acc_next;
    logic        [DUTY_W-1:0]  duty_reg,      duty_next;
    logic signed [ERR_W-1:0]   err_reg,       err_next;
    logic signed [DT_W-1:0]    dt_reg,        dt_next;
    logic signed [SUM_W-1:0]   acc_reg,       acc_next;
    logic signed [ISUM_W-1:0]  isum_reg,      isum_next;
    logic signed [KPROD_W-1:0] kprod_reg,     kprod_next;

    // Output stage
    logic                      m_valid_reg,   m_valid_next;
    logic        [DUTY_W-1:0]  m_duty_reg,    m_duty_next;
    logic        [TEMP_W-1:0]  m_temp_reg,    m_temp_next;

    // Step intermediates
    logic signed [15:0]        kp;
    logic        [PROD_W-1:0]  pshift;
    logic        [TEMP_W-1:0]  t_sat;
    logic signed [FULL_W-1:0]  full;
    logic signed [FULL_W-1:0]  full_sh;
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [SUM_W-1:0]   total;
    logic signed [SUM_W-1:0]   quot;
    logic                      out_free;

    mpfd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mpfd_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (in_xfer),
        .temp_in    (s_tdata[11:0]),
        .pot_in     (s_tdata[23:12]),
        .group_done (group_done),
        .temp_med   (temp_med),
        .pot_med    (pot_med)
    );

    mpfd_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // Take pairs only while the sequencer is at rest
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign kp       = $signed(cfg.prop_gain);

    always_comb begin
        state_next     = state_reg;
        cur_temp_next  = cur_temp_reg;
        prev_temp_next = prev_temp_reg;
        integ_acc_next = integ_acc_reg;
        duty_next      = duty_reg;
        err_next       = err_reg;
        dt_next        = dt_reg;
        acc_next       = acc_reg;
        isum_next      = isum_reg;
        kprod_next     = kprod_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_duty_next    = m_duty_reg;
        m_temp_next    = m_temp_reg;
        mul_a          = '0;
        mul_b          = '0;

        // Median temperature to Q12 degrees, saturated
        pshift = $unsigned(prod) >> ADC_BITS;
        t_sat  = (pshift > PROD_W'(T_MAX)) ? T_MAX : pshift[TEMP_W-1:0];

        // Integral: recombine the two half products, floor by 2^8, saturate
        full    = (FULL_W'(prod) <<< IHALF_W) + FULL_W'(kprod_reg);
        full_sh = full >>> KP_SHIFT;
        if (full_sh > FULL_W'(I_MAX)) begin
            integ_sat = I_MAX;
        end else if (full_sh < FULL_W'(I_MIN)) begin
            integ_sat = I_MIN;
        end else begin
            integ_sat = full_sh[INTEG_W-1:0];
        end

        // duty * 2^25 + 5 * sum
        total = acc_reg + $signed(SUM_W'(duty_reg) << DUTY_SHIFT);
        quot  = total >>> DUTY_SHIFT;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && group_done) begin
                    state_next = ST_MUL_T;
                end
            end
            ST_MUL_T: begin
                mul_a      = MUL_A_W'(TEMP_SCALE);
                mul_b      = $signed(MUL_B_W'(temp_med));
                state_next = ST_TEMP;
            end
            ST_TEMP: begin
                // Advance the temperature history and form error and difference
                prev_temp_next = cur_temp_reg;
                cur_temp_next  = t_sat;
                err_next       = $signed(ERR_W'({pot_med, {FRAC_BITS{1'b0}}})
                                       + ERR_W'({cfg.desired_temp, {FRAC_BITS{1'b0}}})
                                       - ERR_W'(t_sat));
                dt_next        = $signed(DT_W'(t_sat) - DT_W'(cur_temp_reg));
                state_next     = ST_MUL_D;
            end
            ST_MUL_D: begin
                mul_a      = $signed(MUL_A_W'(cfg.derivative_gain));
                mul_b      = MUL_B_W'(dt_reg);
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                // Derivative term in Q24
                acc_next   = SUM_W'(prod) <<< FRAC_BITS;
                mul_a      = $signed(MUL_A_W'(cfg.integral_step));
                mul_b      = err_reg;
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                isum_next  = ISUM_W'(integ_acc_reg) + ISUM_W'(prod >>> ISTEP_SHIFT);
                mul_a      = MUL_A_W'(kp);
                mul_b      = MUL_B_W'(err_reg);
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                // Add the proportional term
                acc_next   = acc_reg + (SUM_W'(prod) <<< PROP_SHIFT);
                mul_a      = $signed(MUL_A_W'(isum_reg[IHALF_W-1:0]));
                mul_b      = MUL_B_W'(kp);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                kprod_next = KPROD_W'(prod);
                mul_a      = MUL_A_W'($signed(isum_reg[ISUM_W-1:IHALF_W]));
                mul_b      = MUL_B_W'(kp);
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                integ_acc_next = integ_sat;
                acc_next       = acc_reg + SUM_W'(integ_sat);
                state_next     = ST_SCALE;
            end
            ST_SCALE: begin
                acc_next   = (acc_reg <<< 2) + acc_reg;
                state_next = ST_TOTAL;
            end
            ST_TOTAL: begin
                // Hold until the output register can take the transfer
                if (out_free) begin
                    if (total < 0) begin
                        duty_next = '0;
                    end else if (quot > $signed(SUM_W'(cfg.output_max))) begin
                        duty_next = cfg.output_max;
                    end else begin
                        duty_next = quot[DUTY_W-1:0];
                    end
                    m_valid_next = 1'b1;
                    m_duty_next  = duty_next;
                    m_temp_next  = cur_temp_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and PID state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_temp_reg  <= '0;
            prev_temp_reg <= '0;
            integ_acc_reg <= '0;
            duty_reg      <= DUTY_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_temp_reg  <= cur_temp_next;
            prev_temp_reg <= prev_temp_next;
            integ_acc_reg <= integ_acc_next;
            duty_reg      <= duty_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Working registers and output payload
    always_ff @(posedge aclk) begin
        err_reg    <= err_next;
        dt_reg     <= dt_next;
        acc_reg    <= acc_next;
        isum_reg   <= isum_next;
        kprod_reg  <= kprod_next;
        m_duty_reg <= m_duty_next;
        m_temp_reg <= m_temp_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_temp_reg, m_duty_reg};

`ifndef SYNTHESIS
    // A result appears only from the final step of the sequence
    a_valid_from_total: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_TOTAL)
        else $error("result raised outside the final step");

    // The third pair of a group starts the sequence
    a_group_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && group_done |=> state_reg == ST_MUL_T)
        else $error("completed group did not start the sequence");

    // A pending result respects the clamp
    a_duty_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_duty_reg <= cfg.output_max)
        else $error("duty above output_max");

    // A free output lets the final step finish at once
    a_total_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TOTAL && out_free |=> state_reg == ST_IDLE && m_valid_reg)
        else $error("final step did not retire");
`endif

endmodule
`default_nettype wire

/* src/mpfd_regs.sv */
// Configuration register file with an APB-style write and read port.
`default_nettype none
module mpfd_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mpfd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mpfd_pkg::DATA_W-1:0] pwdata,
    output logic      [mpfd_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output mpfd_pkg::cfg_t                  cfg
);
    import mpfd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_PROP_GAIN:    cfg_next.prop_gain       = pwdata[15:0];
                REG_DERIV_GAIN:   cfg_next.derivative_gain = pwdata[23:0];
                REG_INTEG_STEP:   cfg_next.integral_step   = pwdata[31:0];
                REG_DESIRED_TEMP: cfg_next.desired_temp    = pwdata[7:0];
                REG_OUTPUT_MAX:   cfg_next.output_max      = pwdata[DUTY_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain       <= PROP_GAIN_RESET;
            cfg_reg.derivative_gain <= DERIV_GAIN_RESET;
            cfg_reg.integral_step   <= INTEG_STEP_RESET;
            cfg_reg.desired_temp    <= DESIRED_TEMP_RESET;
            cfg_reg.output_max      <= OUTPUT_MAX_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_PROP_GAIN:    prdata = DATA_W'(cfg_reg.prop_gain);
            REG_DERIV_GAIN:   prdata = DATA_W'(cfg_reg.derivative_gain);
            REG_INTEG_STEP:   prdata = DATA_W'(cfg_reg.integral_step);
            REG_DESIRED_TEMP: prdata = DATA_W'(cfg_reg.desired_temp);
            REG_OUTPUT_MAX:   prdata = DATA_W'(cfg_reg.output_max);
            default:          prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* src/mpfd_window.sv */
// Three-deep sample windows for temperature and pot, with median of three.
`default_nettype none
module mpfd_window (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         wr_en,
    input  wire logic [mpfd_pkg::SAMPLE_W-1:0] temp_in,
    input  wire logic [mpfd_pkg::SAMPLE_W-1:0] pot_in,
    output logic                              group_done,
    output logic      [mpfd_pkg::WIN_W-1:0]    temp_med,
    output logic      [mpfd_pkg::WIN_W-1:0]    pot_med
);
    import mpfd_pkg::*;

    logic [WIN_W-1:0] temp_win_reg [3];
    logic [WIN_W-1:0] pot_win_reg  [3];
    logic [1:0]       slot_reg;
    logic [1:0]       slot;

    function automatic logic [WIN_W-1:0] med3(input logic [WIN_W-1:0] a,
                                              input logic [WIN_W-1:0] b,
                                              input logic [WIN_W-1:0] c);
        logic [WIN_W-1:0] lo;
        logic [WIN_W-1:0] hi;
        logic [WIN_W-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // Slot three never occurs; treat it as the first slot of a group
    assign slot       = (slot_reg == 2'd3) ? 2'd2 : slot_reg;
    assign group_done = (slot == 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= 2'd2;
            for (int i = 0; i < 3; i++) begin
                temp_win_reg[i] <= '0;
                pot_win_reg[i]  <= '0;
            end
        end else if (wr_en) begin
            temp_win_reg[slot] <= temp_in[WIN_W-1:0];
            pot_win_reg[slot]  <= pot_in[WIN_W-1:0];
            slot_reg           <= group_done ? 2'd2 : slot - 2'd1;
        end
    end

    assign temp_med = med3(temp_win_reg[0], temp_win_reg[1], temp_win_reg[2]);
    assign pot_med  = med3(pot_win_reg[0], pot_win_reg[1], pot_win_reg[2]);

endmodule
`default_nettype wire

/* src/mpfd_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none
module mpfd_mul (
    input  wire logic                               aclk,
    input  wire logic signed [mpfd_pkg::MUL_A_W-1:0] mul_a,
    input  wire logic signed [mpfd_pkg::MUL_B_W-1:0] mul_b,
    output logic signed      [mpfd_pkg::PROD_W-1:0]  prod
);
    import mpfd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire
